// ===== hdl/dqmm_pkg.sv =====
// Shared types, constants and index helpers for the min/max deque.
package dqmm_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int COUNT_W  = 5;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int SUM_W    = IDX_W + 1;

  typedef enum logic [1:0] {
    CMD_PUSH_FRONT = 2'd0,
    CMD_PUSH_BACK  = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_BACK   = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
    logic [COUNT_W-1:0]       count;
    logic                     empty_error;
    logic                     full_error;
  } out_t;

  typedef struct packed {
    logic              we;
    logic [IDX_W-1:0]  waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [IDX_W-1:0]  raddr;
  } mem_req_t;

  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] x);
    return (x == IDX_W'(CAPACITY - 1)) ? '0 : IDX_W'(x + 1'b1);
  endfunction

  function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] x);
    return (x == '0) ? IDX_W'(CAPACITY - 1) : IDX_W'(x - 1'b1);
  endfunction

endpackage

// ===== hdl/dqmm_store.sv =====
// Ring entry store: one write port, one read port with registered data.
module dqmm_store
  import dqmm_pkg::*;
(
  input  logic                     clk,
  input  mem_req_t                 req,
  output logic signed [DATA_W-1:0] rd_data
);

  logic [DATA_W-1:0] mem [CAPACITY];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

// ===== hdl/deque_with_min_max_top.sv =====
// Top level of the bounded deque with front/back/min/max report.
//
// in_data beat: cmd (push front, push back, pop front, pop back) and value.
// out_data beat: front, back, min, max of held entries, count and the
// empty/full error flags; exactly one out beat per in beat, in order.
// Both channels are valid/ready.
//
// The command is applied first, then a scan over the held
// entries through the store's single read port, one entry per cycle, with
// one shared min/max comparator pair. Each entry is compared once its
// registered read data returns; after the last, the FSM enters S_DONE and
// raises out_valid once the out register is free. in_ready returns with
// out_valid, so a new item is taken only after the last report is
// registered. An empty queue reports zeros without a scan.
//
// The out register holds a finished beat while the receiver stalls; the
// next item may be accepted meanwhile, and its result waits until the
// register is free. Reset empties the queue (front 0, count 0); the store
// contents are not cleared and are never read before being written.
module deque_with_min_max_top
  import dqmm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state;
  logic [IDX_W-1:0]  front_index;
  logic [IDX_W-1:0]  front_index_next;
  logic [CNT_W-1:0]  held_count;
  logic [CNT_W-1:0]  held_count_next;
  logic [CNT_W-1:0]  issue_off;
  logic [IDX_W-1:0]  rd_ptr;
  logic              data_vld;
  logic              data_first;
  logic              data_last;
  logic              empty_err;
  logic              full_err;
  logic              in_fire;
  logic [SUM_W-1:0]  back_sum;
  logic [IDX_W-1:0]  back_slot;
  logic signed [DATA_W-1:0] rd_data;
  mem_req_t          mem_req;
  out_t              res;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;

  assign back_sum  = SUM_W'(front_index) + SUM_W'(held_count);
  assign back_slot = (back_sum >= SUM_W'(CAPACITY)) ? IDX_W'(back_sum - SUM_W'(CAPACITY))
                                                    : IDX_W'(back_sum);

  always_comb begin
    front_index_next = front_index;
    held_count_next  = held_count;
    empty_err        = 1'b0;
    full_err         = 1'b0;
    mem_req.we       = 1'b0;
    mem_req.waddr    = back_slot;
    mem_req.wdata    = in_data.value;
    unique case (in_data.cmd)
      CMD_PUSH_FRONT: begin
        if (held_count == CNT_W'(CAPACITY)) begin
          full_err = 1'b1;
        end else begin
          front_index_next = idx_dec(front_index);
          mem_req.we       = in_fire;
          mem_req.waddr    = front_index_next;
          held_count_next  = CNT_W'(held_count + 1'b1);
        end
      end
      CMD_PUSH_BACK: begin
        if (held_count == CNT_W'(CAPACITY)) begin
          full_err = 1'b1;
        end else begin
          mem_req.we      = in_fire;
          held_count_next = CNT_W'(held_count + 1'b1);
        end
      end
      CMD_POP_FRONT: begin
        if (held_count == '0) begin
          empty_err = 1'b1;
        end else begin
          front_index_next = idx_inc(front_index);
          held_count_next  = CNT_W'(held_count - 1'b1);
        end
      end
      CMD_POP_BACK: begin
        if (held_count == '0) begin
          empty_err = 1'b1;
        end else begin
          held_count_next = CNT_W'(held_count - 1'b1);
        end
      end
      default: begin
      end
    endcase
    mem_req.re    = (state == S_SCAN) && (issue_off != held_count);
    mem_req.raddr = rd_ptr;
  end

  dqmm_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      front_index <= '0;
      held_count  <= '0;
      issue_off   <= '0;
      data_vld    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      data_vld <= mem_req.re;
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            front_index <= front_index_next;
            held_count  <= held_count_next;
            issue_off   <= '0;
            state       <= (held_count_next == '0) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (mem_req.re) begin
            issue_off <= CNT_W'(issue_off + 1'b1);
          end
          if (data_vld && data_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    data_first <= (issue_off == '0);
    data_last  <= (issue_off == CNT_W'(held_count - 1'b1));
    if (in_fire) begin
      rd_ptr          <= front_index_next;
      res.front_value <= '0;
      res.back_value  <= '0;
      res.min_value   <= '0;
      res.max_value   <= '0;
      res.count       <= COUNT_W'(held_count_next);
      res.empty_error <= empty_err;
      res.full_error  <= full_err;
    end else if (mem_req.re) begin
      rd_ptr <= idx_inc(rd_ptr);
    end
    if (data_vld) begin
      if (data_first) begin
        res.front_value <= rd_data;
        res.min_value   <= rd_data;
        res.max_value   <= rd_data;
      end else begin
        if (rd_data < res.min_value) begin
          res.min_value <= rd_data;
        end
        if (rd_data > res.max_value) begin
          res.max_value <= rd_data;
        end
      end
      if (data_last) begin
        res.back_value <= rd_data;
      end
    end
    if (state == S_DONE && (!out_valid || out_ready)) begin
      out_data <= res;
    end
  end

endmodule

// ===== hdl/dqmm_checker.sv =====
// Port-level checks for the min/max deque, bound to the top level.
module dqmm_checker
  import dqmm_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input in_t  in_data,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready high right after an accepted beat");

  a_one_error: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.empty_error && out_data.full_error))
    else $error("both error flags set");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_data.count <= COUNT_W'(CAPACITY))
    else $error("count beyond capacity");

  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.count == '0 |->
      out_data.front_value == '0 && out_data.back_value == '0 &&
      out_data.min_value == '0 && out_data.max_value == '0)
    else $error("nonzero report on empty queue");

  a_min_max_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.count != '0 |->
      out_data.min_value <= out_data.front_value &&
      out_data.front_value <= out_data.max_value &&
      out_data.min_value <= out_data.back_value &&
      out_data.back_value <= out_data.max_value)
    else $error("front/back outside min/max");

endmodule

bind deque_with_min_max_top dqmm_checker u_dqmm_checker (.*);

// ===== dv/dqmm_checker.sv =====
// Channel monitor for the min/max deque: predicts each report and compares it.
`timescale 1ns / 1ps

module dqmm_monitor
  import dqmm_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_ready,
  input  in_t  in_data,
  input  logic out_valid,
  input  logic out_ready,
  input  out_t out_data,
  output int   mismatches,
  output int   pending
);

  logic signed [DATA_W-1:0] shadow_store [CAPACITY];
  int   shadow_front = 0;
  int   shadow_count = 0;
  out_t expected_reports [$];

  function automatic out_t apply_command(in_t beat);
    out_t                     rep;
    logic signed [DATA_W-1:0] e;
    int                       i;
    rep = '0;
    case (beat.cmd)
      CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
        if (shadow_count >= CAPACITY) begin
          rep.full_error = 1'b1;
        end else if (beat.cmd == CMD_PUSH_FRONT) begin
          shadow_front = (shadow_front + CAPACITY - 1) % CAPACITY;
          shadow_store[shadow_front] = beat.value;
          shadow_count++;
        end else begin
          shadow_store[(shadow_front + shadow_count) % CAPACITY] = beat.value;
          shadow_count++;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          rep.empty_error = 1'b1;
        end else begin
          if (beat.cmd == CMD_POP_FRONT) shadow_front = (shadow_front + 1) % CAPACITY;
          shadow_count--;
        end
      end
    endcase
    if (shadow_count != 0) begin
      rep.front_value = shadow_store[shadow_front];
      rep.back_value  = shadow_store[(shadow_front + shadow_count - 1) % CAPACITY];
      rep.min_value   = rep.front_value;
      rep.max_value   = rep.front_value;
      for (i = 1; i < shadow_count; i++) begin
        e = shadow_store[(shadow_front + i) % CAPACITY];
        if (e < rep.min_value) rep.min_value = e;
        if (e > rep.max_value) rep.max_value = e;
      end
    end
    rep.count = COUNT_W'(shadow_count);
    return rep;
  endfunction

  task automatic check_field(string name, logic signed [DATA_W-1:0] exp,
                             logic signed [DATA_W-1:0] act);
    if (exp !== act) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp, act);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst) begin
      shadow_front = 0;
      shadow_count = 0;
      expected_reports.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_reports.size() == 0) begin
          $display("%0t: unexpected out beat, expected none, actual %p", $time, out_data);
          mismatches++;
        end else begin
          want = expected_reports[0];
          expected_reports.delete(0);
          check_field("front_value", want.front_value, out_data.front_value);
          check_field("back_value", want.back_value, out_data.back_value);
          check_field("min_value", want.min_value, out_data.min_value);
          check_field("max_value", want.max_value, out_data.max_value);
          check_field("count", DATA_W'(want.count), DATA_W'(out_data.count));
          check_field("empty_error", DATA_W'(want.empty_error),
                      DATA_W'(out_data.empty_error));
          check_field("full_error", DATA_W'(want.full_error),
                      DATA_W'(out_data.full_error));
        end
      end
      if (in_valid && in_ready) begin
        expected_reports.insert(expected_reports.size(), apply_command(in_data));
      end
    end
    pending = expected_reports.size();
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the min/max deque testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
  import dqmm_pkg::*;
();

  localparam int IDLE_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1050;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  int   mismatches;
  int   pending;

  bit   send_burst = 1'b0;
  bit   recv_burst = 1'b0;
  int   recv_stall = 0;
  int   recv_beats = 0;
  int   idle_cycles = 0;

  deque_with_min_max_top dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  dqmm_monitor u_monitor (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // receiver: random stall after each beat, with stall-free stretches
  always @(posedge clk) begin
    int n;
    if (rst) begin
      out_ready  <= 1'b0;
      recv_stall <= 0;
    end else if (out_ready && out_valid) begin
      recv_beats++;
      if (recv_beats % 48 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      n = recv_burst ? 0 : $urandom_range(0, 14);
      if (n == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready  <= 1'b0;
        recv_stall <= n;
      end
    end else if (!out_ready) begin
      if (recv_stall <= 1) out_ready <= 1'b1;
      else recv_stall <= recv_stall - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send(cmd_t c, logic signed [DATA_W-1:0] v);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data.cmd   <= c;
    in_data.value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 5))
      0:       return 32'sh7fffffff;
      1:       return 32'sh80000000;
      2, 3:    return $signed(DATA_W'($urandom_range(0, 6))) - 3;
      default: return $signed($urandom());
    endcase
  endfunction

  initial begin
    int i;
    int push_pct;
    cmd_t c;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // empty pops, extremes, fill to full, pushes while full, pops, a final push
    send(CMD_POP_FRONT, 32'sd5);
    send(CMD_POP_BACK, -32'sd5);
    send(CMD_PUSH_BACK, 32'sh7fffffff);
    send(CMD_PUSH_FRONT, 32'sh80000000);
    send(CMD_PUSH_BACK, 32'sd0);
    send(CMD_PUSH_FRONT, -32'sd1);
    for (i = 0; i < 12; i++)
      send(i[0] ? CMD_PUSH_FRONT : CMD_PUSH_BACK, $signed($urandom()));
    send(CMD_PUSH_FRONT, 32'sd1);
    send(CMD_PUSH_BACK, -32'sd1);
    send(CMD_POP_FRONT, 32'sd0);
    send(CMD_POP_BACK, 32'sd0);
    send(CMD_PUSH_BACK, 32'sh7fffffff);

    push_pct = 50;
    for (i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 30 == 0) begin
        case ($urandom_range(0, 4))
          0: push_pct = 90;
          1: push_pct = 70;
          2: push_pct = 50;
          3: push_pct = 30;
          default: push_pct = 10;
        endcase
        send_burst = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < push_pct)
        c = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
      else
        c = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
      send(c, pick_value());
    end
    in_valid <= 1'b0;

    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (40) @(posedge clk);
    @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
